[rtl/led_pwm_frame_builder_defines.svh]
// Assertion macros shared by the frame builder checker.
// No dependencies; included by files that assert.
`ifndef LED_PWM_FRAME_BUILDER_DEFINES_SVH
`define LED_PWM_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define LPFB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define LPFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lpfb_pkg.sv]
// Types and constants of the LED PWM frame builder.
// No dependencies; imported by every module of the block.
package lpfb_pkg;

    // Command request as taken on the input port
    typedef struct packed {
        logic        command;
        logic [4:0]  target_output;
        logic [15:0] level;
    } t_cmd_req;

    // One frame word as shown on the result port
    typedef struct packed {
        logic [15:0] frame_word;
        logic        last_word;
    } t_frame_res;

    // Classified request held in the queue
    typedef struct packed {
        logic        lit;
        logic [4:0]  target_output;
        logic [15:0] level;
    } t_work;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef logic [5:0] t_logical;

    // Command codes
    localparam logic CMD_LIGHT_ONE = 1'b0;
    localparam logic CMD_ALL_OFF   = 1'b1;

    // Header
    localparam logic [5:0]  WRITE_CODE   = 6'h25;
    localparam int          CH_PER_BOARD = 12;

    // Configuration register map
    localparam int          PADDR_W        = 4;
    localparam logic [1:0]  REG_FUNC_CTRL  = 2'd0;
    localparam logic [1:0]  REG_BRIGHT_B   = 2'd1;
    localparam logic [1:0]  REG_BRIGHT_G   = 2'd2;
    localparam logic [1:0]  REG_BRIGHT_R   = 2'd3;
    localparam logic [4:0]  FUNC_CTRL_RST  = 5'd22;
    localparam logic [6:0]  BRIGHT_RST     = 7'd127;

    // Word slots within one board: two header words then channels 11..0
    localparam logic [3:0]  SLOT_HDR_HI = 4'd0;
    localparam logic [3:0]  SLOT_HDR_LO = 4'd1;
    localparam logic [3:0]  SLOT_LAST   = 4'd13;

endpackage

[rtl/led_pwm_frame_builder.sv]
// LED PWM frame builder top level: register port, front end, queue, back end.
// Depends on lpfb_pkg, lpfb_front, lpfb_queue, lpfb_back.
// Each accepted command yields one frame of 14*BOARDS words (28 at two boards),
// one word per cycle on o_res with o_res_valid high; the receiver cannot stall,
// so words must be taken as they come. The back-end word sequencer sets the
// rate, and frames follow with no gap while commands keep coming. A command
// passes the front holding stage, the queue and the sequencer before its first
// word is registered on o_res. The holding stage and two-entry queue let up to
// three commands wait behind the frame in progress; busy rises when all are full.
module led_pwm_frame_builder #(
    parameter int BOARDS = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lpfb_pkg::t_cmd_req           i_req,
    output logic                         o_res_valid,
    output lpfb_pkg::t_frame_res         o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpfb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lpfb_pkg::*;

    logic [4:0]  r_func;
    logic [6:0]  r_blue;
    logic [6:0]  r_green;
    logic [6:0]  r_red;
    logic        w_wr;
    logic [1:0]  w_idx;
    logic [31:0] w_header;
    logic        w_push;
    logic        w_pop;
    t_work       w_push_data;
    t_work       w_pop_data;
    t_q_stat     w_q_stat;

    // register port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func  <= FUNC_CTRL_RST;
            r_blue  <= BRIGHT_RST;
            r_green <= BRIGHT_RST;
            r_red   <= BRIGHT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_FUNC_CTRL: r_func  <= pwdata[4:0];
                REG_BRIGHT_B:  r_blue  <= pwdata[6:0];
                REG_BRIGHT_G:  r_green <= pwdata[6:0];
                REG_BRIGHT_R:  r_red   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // read-back
    always_comb begin
        case (w_idx)
            REG_FUNC_CTRL: prdata = {27'd0, r_func};
            REG_BRIGHT_B:  prdata = {25'd0, r_blue};
            REG_BRIGHT_G:  prdata = {25'd0, r_green};
            REG_BRIGHT_R:  prdata = {25'd0, r_red};
            default:       prdata = 32'd0;
        endcase
    end

    // board header word pair
    assign w_header = {WRITE_CODE, r_func, r_blue, r_green, r_red};

    lpfb_front #(
        .BOARDS (BOARDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    lpfb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_q_stat)
    );

    lpfb_back #(
        .BOARDS (BOARDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_header    (w_header),
        .i_q_stat    (w_q_stat),
        .i_pop_data  (w_pop_data),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

[rtl/lpfb_front.sv]
// Front end: takes command requests, classifies them and pushes them to the queue.
// Depends on lpfb_pkg.
module lpfb_front #(
    parameter int BOARDS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lpfb_pkg::t_cmd_req i_req,
    output logic               o_busy,
    input  lpfb_pkg::t_q_stat  i_q_stat,
    output logic               o_push,
    output lpfb_pkg::t_work    o_push_data
);
    import lpfb_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_work  r_work;
    t_work  w_class;
    logic   w_accept;

    // classify: lit only for a light command with an index on the chain
    always_comb begin
        w_class.lit = (i_req.command == CMD_LIGHT_ONE) &&
                      (int'(i_req.target_output) < CH_PER_BOARD * BOARDS);
        w_class.target_output = i_req.target_output;
        w_class.level         = i_req.level;
    end

    // holding stage drains to the queue when there is room
    assign o_push      = r_valid && !i_q_stat.full;
    assign o_busy      = r_valid && i_q_stat.full;
    assign w_accept    = i_start && !o_busy;
    assign o_push_data = r_work;

    always_comb begin
        n_valid = w_accept || (r_valid && !o_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_work <= w_class;
        end
    end

endmodule

[rtl/lpfb_queue.sv]
// Two-entry request queue between front and back ends.
// Depends on lpfb_pkg.
module lpfb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpfb_pkg::t_work   i_push_data,
    input  logic              i_pop,
    output lpfb_pkg::t_work   o_pop_data,
    output lpfb_pkg::t_q_stat o_stat
);
    import lpfb_pkg::*;

    t_work       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[rtl/lpfb_back.sv]
// Back end: word sequencer that emits one frame word per cycle while a frame is in progress.
// Depends on lpfb_pkg.
module lpfb_back #(
    parameter int BOARDS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_header,
    input  lpfb_pkg::t_q_stat    i_q_stat,
    input  lpfb_pkg::t_work      i_pop_data,
    output logic                 o_pop,
    output logic                 o_res_valid,
    output lpfb_pkg::t_frame_res o_res
);
    import lpfb_pkg::*;

    localparam int BW = (BOARDS > 1) ? $clog2(BOARDS) : 1;
    localparam logic [BW-1:0] BOARD_FIRST = BW'(BOARDS - 1);

    logic          r_active;
    t_work         r_work;
    logic [BW-1:0] r_board;
    logic [3:0]    r_slot;
    logic          r_res_valid;
    t_frame_res    r_res;
    logic          w_final;
    logic [3:0]    w_chan;
    t_logical      w_logical;
    logic [15:0]   w_word;

    // frame ends on the last channel of board zero
    assign w_final = r_active && (r_board == '0) && (r_slot == SLOT_LAST);
    assign o_pop   = !i_q_stat.empty && (!r_active || w_final);

    // channel and its interleaved logical output
    always_comb begin
        w_chan    = SLOT_LAST - r_slot;
        w_logical = t_logical'(int'(w_chan[3:1]) * 2 * BOARDS +
                               2 * int'(r_board) + int'(w_chan[0]));
    end

    // word select
    always_comb begin
        case (r_slot)
            SLOT_HDR_HI: w_word = i_header[31:16];
            SLOT_HDR_LO: w_word = i_header[15:0];
            default: begin
                if (r_work.lit && (w_logical == t_logical'(r_work.target_output))) begin
                    w_word = r_work.level;
                end else begin
                    w_word = 16'd0;
                end
            end
        endcase
    end

    // sequencer counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_board     <= BOARD_FIRST;
            r_slot      <= SLOT_HDR_HI;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
                r_board  <= BOARD_FIRST;
                r_slot   <= SLOT_HDR_HI;
            end else if (w_final) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                if (r_slot == SLOT_LAST) begin
                    r_slot  <= SLOT_HDR_HI;
                    r_board <= r_board - 1'b1;
                end else begin
                    r_slot <= r_slot + 4'd1;
                end
            end
        end
    end

    // request payload and output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_pop_data;
        end
        r_res.frame_word <= w_word;
        r_res.last_word  <= w_final;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

[rtl/lpfb_checker.sv]
// Port-level checker for the LED PWM frame builder, bound to the top level.
// Depends on lpfb_pkg and led_pwm_frame_builder_defines.svh.
`include "led_pwm_frame_builder_defines.svh"

module lpfb_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_res_valid,
    input lpfb_pkg::t_frame_res o_res
);
    import lpfb_pkg::*;

    // a frame is streamed without gaps up to its last word
    `LPFB_ASSERT_NEXT(a_frame_contiguous, o_res_valid && !o_res.last_word, o_res_valid, "gap inside frame")

    // after a last word comes nothing or a new header
    `LPFB_ASSERT_NEXT(a_next_is_header, o_res_valid && o_res.last_word, !o_res_valid || (o_res.frame_word[15:10] == WRITE_CODE), "frame not followed by header")

    // a burst always opens with the header high word
    `LPFB_ASSERT_NOW(a_burst_opens_header, o_res_valid && !$past(o_res_valid), o_res.frame_word[15:10] == WRITE_CODE, "frame does not open with header")

endmodule

bind led_pwm_frame_builder lpfb_checker u_lpfb_checker (.*);
